FILE: design/ssm_pkg.sv
// ----------------------------------------------------------------------------
// ssm_pkg: shared types and constants of the substring search matcher
// Pattern and window sizes, mode codes, register map and the structs that
// pass between the window cells, the front stage and the result stage.
// ----------------------------------------------------------------------------
package ssm_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int WIN_DEPTH   = MAX_PATTERN + 2;
  localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
  localparam int LEN_W       = 5;
  localparam int POS_W       = 16;
  localparam int CNT_W       = 16;
  localparam int BPOS_W      = POS_W + 1;

  localparam logic [BPOS_W-1:0] MAX_TEXT   = BPOS_W'(65535);
  localparam logic [CNT_W-1:0]  COUNT_MAX  = '1;
  localparam logic [7:0]        SPACE_BYTE = 8'h20;

  // mode register codes
  localparam logic [1:0] MODE_FIRST = 2'd0;
  localparam logic [1:0] MODE_LAST  = 2'd1;
  localparam logic [1:0] MODE_ALL   = 2'd2;
  localparam logic [1:0] MODE_WORD  = 2'd3;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [1:0] REG_PAT_LEN  = 2'd2;
  localparam logic [1:0] REG_MODE     = 2'd3;

  typedef struct packed {
    logic cur_ok;   // byte agrees with the pattern for a window ending here
    logic prev_ok;  // byte agrees with the pattern shifted by one
    logic space;    // byte is a space
  } cell_flags_t;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic [1:0]       mode;
    logic             eot;
    logic             ovf;
    logic [POS_W-1:0] textlen;
  } stage_info_t;

  function automatic logic [7:0] pat_byte(input logic [63:0] low, input logic [63:0] high,
                                          input logic [3:0] idx);
    logic [127:0] pat;
    pat = {high, low};
    return pat[{idx, 3'b000} +: 8];
  endfunction

endpackage

FILE: design/ssm_cell.sv
// ----------------------------------------------------------------------------
// ssm_cell: one byte of the sliding text window
// Holds a window byte, hands it to the next cell on every shift and compares
// the byte moving in against the pattern bytes chosen for its place.
// ----------------------------------------------------------------------------
module ssm_cell
  import ssm_pkg::*;
(
  input  logic        clk,
  input  logic        shift,
  input  logic [7:0]  data_in,
  input  logic [7:0]  want_cur,
  input  logic        en_cur,
  input  logic [7:0]  want_prev,
  input  logic        en_prev,
  output logic [7:0]  data_out,
  output cell_flags_t flags
);

  logic [7:0] held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= data_in;
    end
  end

  assign data_out      = held;
  assign flags.cur_ok  = !en_cur || (data_in == want_cur);
  assign flags.prev_ok = !en_prev || (data_in == want_prev);
  assign flags.space   = (data_in == SPACE_BYTE);

endmodule

FILE: design/ssm_stats.sv
// ----------------------------------------------------------------------------
// ssm_stats: match bookkeeping and result register
// Tracks first and last match start, the greedy non-overlapping count and
// builds the result word when the final byte of a text comes through.
// ----------------------------------------------------------------------------
module ssm_stats
  import ssm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             stage_v,
  input  stage_info_t      info,
  input  logic             out_ready,
  output logic             stall,
  output logic             out_valid,
  output logic             found,
  output logic [POS_W-1:0] position,
  output logic [CNT_W-1:0] match_count,
  output logic             overflow
);

  logic [POS_W-1:0]  first_start, first_start_next;
  logic [POS_W-1:0]  last_start, last_start_next;
  logic [CNT_W-1:0]  count_so_far, count_so_far_next;
  logic [BPOS_W-1:0] next_allowed, next_allowed_next;
  logic              seen_match, seen_match_next;
  logic [BPOS_W-1:0] tail_end;
  logic [POS_W-1:0]  pos_next;
  logic              take;

  assign stall = stage_v && info.eot && out_valid && !out_ready;
  assign take  = stage_v && !stall;

  always_comb begin
    first_start_next  = first_start;
    last_start_next   = last_start;
    count_so_far_next = count_so_far;
    next_allowed_next = next_allowed;
    seen_match_next   = seen_match;
    if (info.hit) begin
      if (!seen_match) begin
        first_start_next = info.start;
      end
      seen_match_next = 1'b1;
      last_start_next = info.start;
      if ({1'b0, info.start} >= next_allowed) begin
        if (count_so_far != COUNT_MAX) begin
          count_so_far_next = count_so_far + CNT_W'(1);
        end
        next_allowed_next = {1'b0, info.start} + BPOS_W'(info.len);
      end
    end
  end

  // tail offset of the last match in last mode, clamped at zero; first match start otherwise
  always_comb begin
    tail_end = {1'b0, last_start_next} + BPOS_W'(info.len);
    pos_next = '0;
    if (seen_match_next) begin
      if (info.mode == MODE_LAST) begin
        if (tail_end <= {1'b0, info.textlen}) begin
          pos_next = info.textlen - POS_W'(info.len) - last_start_next;
        end
      end else begin
        pos_next = first_start_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_start  <= '0;
      last_start   <= '0;
      count_so_far <= '0;
      next_allowed <= '0;
      seen_match   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        if (info.eot) begin
          first_start  <= '0;
          last_start   <= '0;
          count_so_far <= '0;
          next_allowed <= '0;
          seen_match   <= 1'b0;
        end else begin
          first_start  <= first_start_next;
          last_start   <= last_start_next;
          count_so_far <= count_so_far_next;
          next_allowed <= next_allowed_next;
          seen_match   <= seen_match_next;
        end
      end
      if (take && info.eot) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && info.eot) begin
      found       <= seen_match_next;
      position    <= pos_next;
      match_count <= count_so_far_next;
      overflow    <= info.ovf;
    end
  end

endmodule

FILE: design/substring_search_matcher.sv
// ----------------------------------------------------------------------------
// substring_search_matcher: streaming pattern search over a byte text
// Matches a text stream against a configured pattern of 1 to 16 bytes and
// reports one result word per text.
// ----------------------------------------------------------------------------
// Text bytes enter one per clock on in_valid/in_ready; the byte marked
// end_of_text closes the text and its result word (found, position,
// match_count, overflow) passes the stage and result registers to out_valid/
// out_ready. Throughput is one byte per cycle, set by the row of 18 window
// cells that shift and compare a full pattern every cycle; input stalls only
// when the end of a further text reaches the result stage while the previous
// result word has not been taken. Pattern, length and mode sit in four 64-bit
// APB registers at byte addresses 0, 8, 16 and 24 and should be written while
// no text is in flight. No clearing pass is needed after reset.
module substring_search_matcher
  import ssm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       text_byte,
  input  logic             end_of_text,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             found,
  output logic [POS_W-1:0] position,
  output logic [CNT_W-1:0] match_count,
  output logic             overflow
);

  logic [63:0]       pattern_low;
  logic [63:0]       pattern_high;
  logic [LEN_W-1:0]  pattern_length;
  logic [1:0]        mode;

  logic [LEN_W-1:0]  len;
  logic [7:0]        want [WIN_DEPTH];
  logic              want_en [WIN_DEPTH];
  logic [7:0]        cell_in [WIN_DEPTH];
  logic [7:0]        cell_out [WIN_DEPTH];
  cell_flags_t       flags [WIN_DEPTH];
  logic              all_cur, all_prev;
  logic [WIN_IDX_W-1:0] sp_idx;

  logic [BPOS_W-1:0] byte_position, bpos_after;
  logic              accept, in_range, shift, stall;
  logic              len_ok, hit;
  logic [BPOS_W-1:0] start_full;
  stage_info_t       stage_info, stage_info_next;
  logic              stage_v;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= LEN_W'(1);
      mode           <= MODE_FIRST;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        REG_PAT_LOW:  pattern_low    <= pwdata;
        REG_PAT_HIGH: pattern_high   <= pwdata;
        REG_PAT_LEN:  pattern_length <= pwdata[LEN_W-1:0];
        REG_MODE:     mode           <= pwdata[1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_PAT_LOW:  prdata = pattern_low;
      REG_PAT_HIGH: prdata = pattern_high;
      REG_PAT_LEN:  prdata = 64'(pattern_length);
      REG_MODE:     prdata = 64'(mode);
      default:      prdata = '0;
    endcase
  end

  // length in force, clamped to 1..MAX_PATTERN
  always_comb begin
    if (pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      len = LEN_W'(MAX_PATTERN);
    end else begin
      len = pattern_length;
    end
  end

  // cell k sees the pattern reversed so that the newest byte meets its last byte
  always_comb begin
    logic [LEN_W-1:0] sel;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      sel        = len - LEN_W'(1) - LEN_W'(k);
      want[k]    = pat_byte(pattern_low, pattern_high, sel[3:0]);
      want_en[k] = (LEN_W'(k) < len) && (k < MAX_PATTERN);
    end
  end

  assign in_ready = !stall;
  assign accept   = in_valid && in_ready;
  assign in_range = byte_position < MAX_TEXT;
  assign shift    = accept && in_range;

  genvar g;
  generate
    for (g = 0; g < WIN_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
        assign cell_in[g] = text_byte;
        ssm_cell u_cell (
          .clk       (clk),
          .shift     (shift),
          .data_in   (cell_in[g]),
          .want_cur  (want[g]),
          .en_cur    (want_en[g]),
          .want_prev (8'h00),
          .en_prev   (1'b0),
          .data_out  (cell_out[g]),
          .flags     (flags[g])
        );
      end else begin : g_body
        assign cell_in[g] = cell_out[g-1];
        ssm_cell u_cell (
          .clk       (clk),
          .shift     (shift),
          .data_in   (cell_in[g]),
          .want_cur  (want[g]),
          .en_cur    (want_en[g]),
          .want_prev (want[g-1]),
          .en_prev   (want_en[g-1]),
          .data_out  (cell_out[g]),
          .flags     (flags[g])
        );
      end
    end
  endgenerate

  always_comb begin
    all_cur  = 1'b1;
    all_prev = 1'b1;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      all_cur  = all_cur && flags[k].cur_ok;
      all_prev = all_prev && flags[k].prev_ok;
    end
  end

  assign sp_idx = WIN_IDX_W'(len) + WIN_IDX_W'(1);

  always_comb begin
    if (mode == MODE_WORD) begin
      len_ok     = byte_position >= BPOS_W'(len);
      start_full = byte_position - BPOS_W'(len);
      hit        = in_range && len_ok && flags[0].space && all_prev &&
                   ((start_full == '0) || flags[sp_idx].space);
    end else begin
      len_ok     = (byte_position + BPOS_W'(1)) >= BPOS_W'(len);
      start_full = byte_position + BPOS_W'(1) - BPOS_W'(len);
      hit        = in_range && len_ok && all_cur;
    end
  end

  assign bpos_after = in_range ? byte_position + BPOS_W'(1) : MAX_TEXT + BPOS_W'(1);

  always_comb begin
    stage_info_next.hit     = hit;
    stage_info_next.start   = start_full[POS_W-1:0];
    stage_info_next.len     = len;
    stage_info_next.mode    = mode;
    stage_info_next.eot     = end_of_text;
    stage_info_next.ovf     = bpos_after > MAX_TEXT;
    stage_info_next.textlen = (bpos_after > MAX_TEXT) ? MAX_TEXT[POS_W-1:0]
                                                      : bpos_after[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      stage_v       <= 1'b0;
    end else if (!stall) begin
      stage_v <= in_valid;
      if (in_valid) begin
        byte_position <= end_of_text ? '0 : bpos_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_info <= stage_info_next;
    end
  end

  ssm_stats u_stats (
    .clk         (clk),
    .rst         (rst),
    .stage_v     (stage_v),
    .info        (stage_info),
    .out_ready   (out_ready),
    .stall       (stall),
    .out_valid   (out_valid),
    .found       (found),
    .position    (position),
    .match_count (match_count),
    .overflow    (overflow)
  );

endmodule

FILE: design/ssm_checker.sv
// ----------------------------------------------------------------------------
// ssm_checker: port-level checks for the substring search matcher
// Watches the result channel and reset behavior of the top level.
// ----------------------------------------------------------------------------
module ssm_checker
  import ssm_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic             found,
  input logic [POS_W-1:0] position,
  input logic [CNT_W-1:0] match_count,
  input logic             overflow
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(position) &&
      $stable(match_count) && $stable(overflow))
    else $error("result word changed while stalled");

  // found is set exactly when the match count is nonzero
  a_found_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (found == (match_count != '0)))
    else $error("found and match_count disagree");

  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> position == '0)
    else $error("position nonzero without a match");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind substring_search_matcher ssm_checker u_ssm_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .found       (found),
  .position    (position),
  .match_count (match_count),
  .overflow    (overflow)
);

FILE: test/tb_substring_search_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_substring_search_matcher: self-checking bench for the substring matcher
// Streams texts through the valid/ready input with random idling, writes the
// pattern registers over APB between phases, predicts each per-text result
// word in a cycle-free model and compares every field at the output side.
// ----------------------------------------------------------------------------
module tb_substring_search_matcher;
  import ssm_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       eot;
  } text_word_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] match_count;
    logic             overflow;
  } search_result_t;

  logic             clk;
  logic             rst         = 1'b1;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [4:0]       paddr       = '0;
  logic [63:0]      pwdata      = '0;
  logic [63:0]      prdata;
  logic             pready;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  logic [7:0]       text_byte   = '0;
  logic             end_of_text = 1'b0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  logic             found;
  logic [POS_W-1:0] position;
  logic [CNT_W-1:0] match_count;
  logic             overflow;

  substring_search_matcher dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .text_byte(text_byte),
    .end_of_text(end_of_text),
    .out_valid(out_valid), .out_ready(out_ready), .found(found), .position(position),
    .match_count(match_count), .overflow(overflow)
  );

  // register shadow
  logic [63:0]      cfg_low  = '0;
  logic [63:0]      cfg_high = '0;
  logic [4:0]       cfg_len  = 5'd1;
  logic [1:0]       cfg_mode = MODE_FIRST;

  // per-text search state
  logic [7:0]       win [WIN_DEPTH];
  int               txt_pos;
  int               first_at;
  int               last_at;
  int               next_free;
  int               hit_count;
  logic             any_hit;

  text_word_t       text_q[$];
  search_result_t   expected_q[$];
  text_word_t       cur;
  search_result_t   want;
  int               words_queued = 0;
  int               words_taken  = 0;
  int               results_seen = 0;
  int               errors       = 0;
  int               gap_left     = 0;
  int               stall_left   = 0;
  logic             calm         = 1'b0;
  logic             hold_off     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_substring_search_matcher NOT OK");
    $finish;
  end

  function automatic logic [7:0] pat_at(input int k);
    logic [127:0] p;
    p = {cfg_high, cfg_low};
    return (k < MAX_PATTERN) ? p[8*k +: 8] : 8'h00;
  endfunction

  function automatic int used_len();
    int l;
    l = cfg_len;
    if (l == 0) l = 1;
    if (l > MAX_PATTERN) l = MAX_PATTERN;
    return l;
  endfunction

  // window bytes off.. (newest first) against the pattern read backwards
  function automatic logic window_agrees(input int off, input int len);
    int k;
    for (k = 0; k < len; k++) begin
      if (off + k >= WIN_DEPTH) return 1'b0;
      if (win[off + k] != pat_at(len - 1 - k)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_text();
    int i;
    for (i = 0; i < WIN_DEPTH; i++) win[i] = 8'h00;
    txt_pos   = 0;
    first_at  = 0;
    last_at   = 0;
    next_free = 0;
    hit_count = 0;
    any_hit   = 1'b0;
  endfunction

  function automatic void take_byte(input logic [7:0] b, input logic eot);
    int             i;
    int             len;
    int             s;
    int             tlen;
    logic           hit;
    search_result_t r;
    len = used_len();
    hit = 1'b0;
    s   = 0;
    if (txt_pos < MAX_TEXT) begin
      for (i = WIN_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = b;
      if (cfg_mode != MODE_WORD) begin
        if (txt_pos + 1 >= len && window_agrees(0, len)) begin
          hit = 1'b1;
          s   = txt_pos + 1 - len;
        end
      end else if (txt_pos >= len && b == SPACE_BYTE && window_agrees(1, len)) begin
        // word must open the text or follow a space
        s = txt_pos - len;
        if (s == 0 || win[len + 1] == SPACE_BYTE) hit = 1'b1;
      end
      if (hit) begin
        if (!any_hit) begin
          first_at = s;
          any_hit  = 1'b1;
        end
        last_at = s;
        if (s >= next_free) begin
          if (hit_count < COUNT_MAX) hit_count++;
          next_free = s + len;
        end
      end
      txt_pos++;
    end else begin
      txt_pos = MAX_TEXT + 1;
    end
    if (eot) begin
      tlen = (txt_pos > MAX_TEXT) ? MAX_TEXT : txt_pos;
      r.found       = any_hit;
      r.position    = '0;
      r.match_count = CNT_W'(hit_count);
      r.overflow    = (txt_pos > MAX_TEXT);
      if (any_hit) begin
        if (cfg_mode == MODE_LAST) begin
          if (last_at + len <= tlen) r.position = POS_W'(tlen - len - last_at);
        end else begin
          r.position = POS_W'(first_at);
        end
      end
      expected_q.push_back(r);
      clear_text();
    end
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long pause
  function automatic int idle_len();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // text word driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        take_byte(text_byte, end_of_text);
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (text_q.size() != 0) begin
          cur = text_q.pop_front();
          in_valid    <= 1'b1;
          text_byte   <= cur.b;
          end_of_text <= cur.eot;
          gap_left = idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result word monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            errors++;
          end
          if (position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, position);
            errors++;
          end
          if (match_count !== want.match_count) begin
            $error("match_count: expected %0d, got %0d", want.match_count, match_count);
            errors++;
          end
          if (overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, overflow);
            errors++;
          end
        end
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  // long receiver hold so the input side backs up
  initial begin
    wait (results_seen >= 30);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic reg_write(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PAT_LOW:  cfg_low  = value;
      REG_PAT_HIGH: cfg_high = value;
      REG_PAT_LEN:  cfg_len  = value[4:0];
      REG_MODE:     cfg_mode = value[1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [127:0] pat, input logic [4:0] len,
                            input logic [1:0] md);
    reg_write(REG_PAT_LOW, pat[63:0]);
    reg_write(REG_PAT_HIGH, pat[127:64]);
    reg_write(REG_PAT_LEN, {59'd0, len});
    reg_write(REG_MODE, {62'd0, md});
  endtask

  function automatic void push_word(input logic [7:0] b, input logic eot);
    text_word_t w;
    w.b   = b;
    w.eot = eot;
    text_q.push_back(w);
    words_queued++;
  endfunction

  function automatic void add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_word(s[i], i == s.len() - 1);
  endfunction

  function automatic logic [127:0] pack_pattern(input string s);
    logic [127:0] p;
    int           i;
    p = '0;
    for (i = 0; i < s.len() && i < MAX_PATTERN; i++) p[8*i +: 8] = s[i];
    return p;
  endfunction

  function automatic logic [7:0] letter();
    case ($urandom_range(0, 2))
      0:       return "a";
      1:       return "b";
      default: return SPACE_BYTE;
    endcase
  endfunction

  // every word taken and every result word back, then let the pipe settle
  task automatic drain();
    do @(posedge clk);
    while (words_taken != words_queued || expected_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(input int n_words);
    logic [127:0] pat;
    logic [4:0]   len;
    logic [7:0]   b;
    int           pushed;
    int           tl;
    int           k;
    int           j;
    int           pick;
    int           plen;
    pushed = 0;
    pick = $urandom_range(0, 19);
    if (pick < 12) len = 5'($urandom_range(1, 3));
    else if (pick < 17) len = 5'($urandom_range(4, 16));
    else if (pick == 17) len = 5'd0;
    else len = 5'($urandom_range(17, 31));
    pat = {$urandom, $urandom, $urandom, $urandom};
    for (k = 0; k < MAX_PATTERN; k++)
      if ($urandom_range(0, 3) != 0) pat[8*k +: 8] = letter();
    calm = ($urandom_range(0, 3) == 0);
    set_config(pat, len, 2'($urandom_range(0, 3)));
    plen = used_len();
    while (pushed < n_words) begin
      tl = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
      k = 0;
      while (k < tl) begin
        pick = $urandom_range(0, 9);
        if (pick < 3 || pick == 9) begin
          // full pattern copy, or one cut short by its last byte
          for (j = 0; j < plen - (pick == 9) && k < tl; j++) begin
            push_word(pat_at(j), k == tl - 1);
            k++;
          end
        end else begin
          if (pick < 5) b = SPACE_BYTE;
          else if (pick < 8) b = letter();
          else b = 8'($urandom);
          push_word(b, k == tl - 1);
          k++;
        end
      end
      pushed += tl;
    end
    drain();
  endtask

  initial begin
    int ph;
    int i;
    clear_text();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset pattern is a single zero byte, first-match mode
    push_word(8'h00, 1'b0);
    push_word(8'hff, 1'b1);
    push_word(8'hff, 1'b1);
    drain();

    // overlapping matches, last one reported from the tail
    set_config(pack_pattern("aba"), 5'd3, MODE_LAST);
    add_text("ababax");
    drain();

    // whole word: preceded by a letter or ending the text does not qualify
    set_config(pack_pattern("ab"), 5'd2, MODE_WORD);
    add_text("ab cab ab");
    add_text("a");
    drain();

    // zero length counts as one byte
    set_config({64'd0, 64'h0000_0000_0000_00ff}, 5'd0, MODE_ALL);
    push_word(8'hff, 1'b0);
    push_word(8'hff, 1'b0);
    push_word(8'h00, 1'b1);
    drain();

    // oversized length clamps to the full sixteen byte pattern
    set_config({128{1'b1}}, 5'd31, MODE_FIRST);
    for (i = 0; i < MAX_PATTERN; i++) push_word(8'hff, i == MAX_PATTERN - 1);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      random_phase(140);
      if (ph == 3) begin
        // text past the position range: count reaches its maximum and overflow is raised
        calm = 1'b1;
        set_config(pack_pattern("a"), 5'd1, MODE_ALL);
        for (i = 0; i < 65537; i++) push_word("a", i == 65536);
        drain();
      end
    end

    drain();
    if (errors == 0) begin
      $display("tb_substring_search_matcher OK");
    end else begin
      $display("tb_substring_search_matcher NOT OK");
    end
    $finish;
  end

endmodule
